@@ hw/rtl/wfc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package wfc_pkg;

  localparam int DefSlots = 32;
  localparam int DefChars = 64;

  localparam logic [7:0] ChApos   = 8'h27;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChPeriod = 8'h2E;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpZ    = 8'h5A;
  localparam logic [7:0] ChNul    = 8'h00;

  typedef enum logic [1:0] {
    ST_COUNTED = 2'd0,
    ST_END     = 2'd1,
    ST_FULL    = 2'd2,
    ST_LONG    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEN_RD,
    S_LEN_CK,
    S_CMP_RD,
    S_CMP_CK,
    S_MATCH,
    S_MISS,
    S_COPY_RD,
    S_COPY_WR,
    S_NEW
  } state_t;

  typedef struct packed {
    logic store_char;
    logic begin_word;
    logic emit_end;
    logic emit_long;
    logic len_rd;
    logic next_slot;
    logic j_clear;
    logic cmp_rd;
    logic next_char;
    logic match_wr;
    logic copy_wr;
    logic new_wr;
    logic emit_full;
  } wfc_cmd_t;

  typedef struct packed {
    logic is_zero;
    logic is_sep;
    logic pending;
    logic err_hold;
    logic too_long;
    logic used_zero;
    logic len_eq;
    logic len_zero;
    logic text_eq;
    logic j_last;
    logic slot_last;
    logic table_full;
  } wfc_stat_t;

  function automatic logic is_separator(input logic [7:0] c);
    return (c == ChNul) || (c == ChSpace) || ((c >= ChTab) && (c <= ChCr)) ||
           (c == ChComma) || (c == ChPeriod);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return ((c >= ChUpA) && (c <= ChUpZ)) ? c + 8'd32 : c;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/wfc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wfc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire wfc_pkg::wfc_stat_t stat,
  output wfc_pkg::wfc_cmd_t       cmd,
  output logic                    busy
);
  import wfc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start && !stat.err_hold && stat.pending && (stat.is_zero || stat.is_sep)) begin
          state_next = stat.used_zero ? S_MISS : S_LEN_RD;
        end
      end
      S_LEN_RD: state_next = S_LEN_CK;
      S_LEN_CK: begin
        if (stat.len_eq) begin
          state_next = stat.len_zero ? S_MATCH : S_CMP_RD;
        end else begin
          state_next = stat.slot_last ? S_MISS : S_LEN_RD;
        end
      end
      S_CMP_RD: state_next = S_CMP_CK;
      S_CMP_CK: begin
        if (!stat.text_eq) begin
          state_next = stat.slot_last ? S_MISS : S_LEN_RD;
        end else if (stat.j_last) begin
          state_next = S_MATCH;
        end else begin
          state_next = S_CMP_RD;
        end
      end
      S_MATCH: state_next = S_IDLE;
      S_MISS: begin
        if (stat.table_full) begin
          state_next = S_IDLE;
        end else begin
          state_next = stat.len_zero ? S_NEW : S_COPY_RD;
        end
      end
      S_COPY_RD: state_next = S_COPY_WR;
      S_COPY_WR: state_next = stat.j_last ? S_NEW : S_COPY_RD;
      S_NEW: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (stat.is_zero) begin
            if (!stat.err_hold && stat.pending) begin
              cmd.begin_word = 1'b1;
            end else begin
              cmd.emit_end = 1'b1;
            end
          end else if (!stat.err_hold) begin
            if (stat.is_sep) begin
              cmd.begin_word = stat.pending;
            end else if (stat.too_long) begin
              cmd.emit_long = 1'b1;
            end else begin
              cmd.store_char = 1'b1;
            end
          end
        end
      end
      S_LEN_RD: cmd.len_rd = 1'b1;
      S_LEN_CK: begin
        if (stat.len_eq) begin
          cmd.j_clear = 1'b1;
        end else begin
          cmd.next_slot = 1'b1;
        end
      end
      S_CMP_RD: cmd.cmp_rd = 1'b1;
      S_CMP_CK: begin
        if (!stat.text_eq) begin
          cmd.next_slot = 1'b1;
        end else if (!stat.j_last) begin
          cmd.next_char = 1'b1;
        end
      end
      S_MATCH: cmd.match_wr = 1'b1;
      S_MISS: begin
        if (stat.table_full) begin
          cmd.emit_full = 1'b1;
        end else begin
          cmd.j_clear = 1'b1;
        end
      end
      S_COPY_RD: cmd.cmp_rd = 1'b1;
      S_COPY_WR: begin
        cmd.copy_wr   = 1'b1;
        cmd.next_char = !stat.j_last;
      end
      S_NEW: cmd.new_wr = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/wfc_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wfc_datapath #(
  parameter int WORD_SLOTS = wfc_pkg::DefSlots,
  parameter int WORD_CHARS = wfc_pkg::DefChars
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [7:0]        char_code,
  input  wire wfc_pkg::wfc_cmd_t cmd,
  output wfc_pkg::wfc_stat_t     stat,
  output logic                   result_strobe,
  output logic [1:0]             status,
  output logic [4:0]             slot_index,
  output logic [15:0]            word_count_now,
  output logic                   first_seen,
  output logic [5:0]             distinct_words
);
  import wfc_pkg::*;

  localparam int SW = (WORD_SLOTS > 1) ? $clog2(WORD_SLOTS) : 1;
  localparam int UW = $clog2(WORD_SLOTS + 1);
  localparam int CW = $clog2(WORD_CHARS);
  localparam int LW = $clog2(WORD_CHARS + 1);
  localparam int TDepth = WORD_SLOTS * WORD_CHARS;
  localparam int TW = (TDepth > 1) ? $clog2(TDepth) : 1;

  logic [7:0]  buf_mem  [WORD_CHARS];
  logic [7:0]  text_mem [TDepth];
  logic [LW-1:0] len_mem  [WORD_SLOTS];
  logic [15:0] tally_mem [WORD_SLOTS];

  logic [LW-1:0] wlen;
  logic [UW-1:0] used;
  logic          err_hold;
  logic [7:0]    first_ch, last_ch;
  logic          eot;
  logic          start_off;
  logic [LW-1:0] len_s;
  logic [UW-1:0] slot;
  logic [TW:0]   base;
  logic [LW-1:0] j;
  logic [7:0]    buf_q, text_q;
  logic [LW-1:0] len_q;
  logic [15:0]   tally_q;

  logic          strip;
  logic [7:0]    low_ch;
  logic [TW-1:0] text_addr;
  logic [CW-1:0] buf_raddr;
  logic [15:0]   tally_inc;

  assign strip     = (wlen >= LW'(2)) && (first_ch == ChApos) && (last_ch == ChApos);
  assign low_ch    = to_lower(char_code);
  assign text_addr = TW'(base + (TW+1)'(j));
  assign buf_raddr = CW'(j + LW'(start_off));
  assign tally_inc = (tally_q == 16'hFFFF) ? tally_q : tally_q + 16'd1;

  always_comb begin
    stat.is_zero    = (char_code == ChNul);
    stat.is_sep     = is_separator(char_code);
    stat.pending    = (wlen != '0);
    stat.err_hold   = err_hold;
    stat.too_long   = (wlen >= LW'(WORD_CHARS));
    stat.used_zero  = (used == '0);
    stat.len_eq     = (len_q == len_s);
    stat.len_zero   = (len_s == '0);
    stat.text_eq    = (text_q == buf_q);
    stat.j_last     = ((LW+1)'(j) + (LW+1)'(1)) == (LW+1)'(len_s);
    stat.slot_last  = ((UW+1)'(slot) + (UW+1)'(1)) == (UW+1)'(used);
    stat.table_full = (used >= UW'(WORD_SLOTS));
  end

  always_ff @(posedge clk) begin
    if (cmd.store_char) begin
      buf_mem[wlen[CW-1:0]] <= low_ch;
    end
    if (cmd.cmp_rd) begin
      buf_q <= buf_mem[buf_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.copy_wr) begin
      text_mem[text_addr] <= buf_q;
    end
    if (cmd.cmp_rd) begin
      text_q <= text_mem[text_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.new_wr) begin
      len_mem[slot[SW-1:0]]   <= len_s;
      tally_mem[slot[SW-1:0]] <= 16'd1;
    end else if (cmd.match_wr) begin
      tally_mem[slot[SW-1:0]] <= tally_inc;
    end
    if (cmd.len_rd) begin
      len_q   <= len_mem[slot[SW-1:0]];
      tally_q <= tally_mem[slot[SW-1:0]];
    end
  end

  // Word-end bookkeeping: stripped word bounds and the slot scan pointers.
  always_ff @(posedge clk) begin
    if (cmd.store_char) begin
      if (wlen == '0) begin
        first_ch <= low_ch;
      end
      last_ch <= low_ch;
    end
    if (cmd.begin_word) begin
      eot       <= (char_code == ChNul);
      start_off <= strip;
      len_s     <= strip ? wlen - LW'(2) : wlen;
      slot      <= '0;
      base      <= '0;
    end else if (cmd.next_slot) begin
      slot <= slot + UW'(1);
      base <= base + (TW+1)'(WORD_CHARS);
    end
    if (cmd.j_clear) begin
      j <= '0;
    end else if (cmd.next_char) begin
      j <= j + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wlen          <= '0;
      used          <= '0;
      err_hold      <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.emit_end | cmd.emit_long | cmd.match_wr |
                       cmd.new_wr | cmd.emit_full;
      // End of text clears the table after its result is formed.
      if (cmd.emit_end || ((cmd.match_wr || cmd.new_wr || cmd.emit_full) && eot)) begin
        wlen     <= '0;
        used     <= '0;
        err_hold <= 1'b0;
      end else begin
        if (cmd.store_char) begin
          wlen <= wlen + LW'(1);
        end else if (cmd.begin_word) begin
          wlen <= '0;
        end
        if (cmd.emit_long || cmd.emit_full) begin
          err_hold <= 1'b1;
        end
        if (cmd.new_wr) begin
          used <= used + UW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.new_wr) begin
      distinct_words <= 6'((UW+1)'(used) + (UW+1)'(1));
    end else begin
      distinct_words <= 6'(used);
    end
    if (cmd.match_wr || cmd.new_wr) begin
      status         <= eot ? ST_END : ST_COUNTED;
      slot_index     <= 5'(slot);
      word_count_now <= cmd.new_wr ? 16'd1 : tally_inc;
      first_seen     <= cmd.new_wr;
    end else begin
      if (cmd.emit_long) begin
        status <= ST_LONG;
      end else if (cmd.emit_full) begin
        status <= ST_FULL;
      end else begin
        status <= ST_END;
      end
      slot_index     <= '0;
      word_count_now <= '0;
      first_seen     <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/word_frequency_counter_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Word frequency counter. One text byte is taken per item while busy is low. At a word end
// the block stays busy while it scans the stored words one slot at a time: for each slot it
// reads and compares the stored length, and when the lengths agree it reads and compares
// the text byte by byte; a match then updates the count. On a miss, if the table is not
// full, it claims a free slot, copies the new word byte by byte and stores its length and
// count. The scan is set by the single read port of the slot text memory.
// A result is registered in the cycle after the item or scan that causes it; result_strobe
// is high for exactly one cycle; the receiver cannot stall it and must take it then.
module word_frequency_counter_unit #(
  parameter int WORD_SLOTS = wfc_pkg::DefSlots,
  parameter int WORD_CHARS = wfc_pkg::DefChars
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  char_code,
  output logic             result_strobe,
  output logic [1:0]       status,
  output logic [4:0]       slot_index,
  output logic [15:0]      word_count_now,
  output logic             first_seen,
  output logic [5:0]       distinct_words
);
  import wfc_pkg::*;

  wfc_cmd_t  cmd;
  wfc_stat_t stat;

  wfc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  wfc_datapath #(
    .WORD_SLOTS (WORD_SLOTS),
    .WORD_CHARS (WORD_CHARS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .char_code      (char_code),
    .cmd            (cmd),
    .stat           (stat),
    .result_strobe  (result_strobe),
    .status         (status),
    .slot_index     (slot_index),
    .word_count_now (word_count_now),
    .first_seen     (first_seen),
    .distinct_words (distinct_words)
  );

endmodule
`default_nettype wire

@@ hw/rtl/wfc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wfc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        result_strobe,
  input wire logic [1:0]  status,
  input wire logic [4:0]  slot_index,
  input wire logic [15:0] word_count_now,
  input wire logic        first_seen,
  input wire logic [5:0]  distinct_words
);
  import wfc_pkg::*;

  // Error results carry no word information.
  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    result_strobe && (status == ST_FULL || status == ST_LONG) |->
      slot_index == 5'd0 && word_count_now == 16'd0 && !first_seen)
    else $error("error result carries word fields");

  // A newly stored word has been seen exactly once.
  a_first_one: assert property (@(posedge clk) disable iff (rst)
    result_strobe && first_seen |-> word_count_now == 16'd1)
    else $error("new word count is not one");

  // A counted word means the table holds at least one word.
  a_counted: assert property (@(posedge clk) disable iff (rst)
    result_strobe && status == ST_COUNTED |->
      distinct_words != 6'd0 && word_count_now != 16'd0)
    else $error("counted word with empty table");

endmodule

bind word_frequency_counter_unit wfc_checker u_wfc_checker (
  .clk            (clk),
  .rst            (rst),
  .result_strobe  (result_strobe),
  .status         (status),
  .slot_index     (slot_index),
  .word_count_now (word_count_now),
  .first_seen     (first_seen),
  .distinct_words (distinct_words)
);
`default_nettype wire
